// ===== src/bmc_pkg.sv =====
// Package for the bracket match corrector: item types, stack sizing,
// bracket character codes and kind helpers. No dependencies.
package bmc_pkg;

  // Stack sizing
  localparam int STACK_DEPTH = 1024;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Bracket characters
  localparam logic [7:0] CH_LROUND  = 8'h28;  // (
  localparam logic [7:0] CH_RROUND  = 8'h29;  // )
  localparam logic [7:0] CH_LSQUARE = 8'h5B;  // [
  localparam logic [7:0] CH_RSQUARE = 8'h5D;  // ]
  localparam logic [7:0] CH_LCURLY  = 8'h7B;  // {
  localparam logic [7:0] CH_RCURLY  = 8'h7D;  // }

  localparam logic [15:0] SAT_MAX = 16'hFFFF;

  // Bracket kind codes held in the stack
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        mismatch;
    logic [15:0] position;
    logic [15:0] error_total;
    logic        out_last;
  } out_item_t;

  // Request from the control logic to the stack
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stk_cmd_t;

  // Stack status seen by the control logic
  typedef struct packed {
    logic  empty;
    logic  full;
    kind_t top;
  } stk_stat_t;

  // Shift control for one cell
  typedef struct packed {
    logic shift_down;
    logic shift_up;
  } cell_op_t;

  // Closer that matches a kind; an unused code corrects to round
  function automatic logic [7:0] kind_closer(input kind_t k);
    logic [7:0] c;
    case (k)
      KIND_ROUND:  c = CH_RROUND;
      KIND_SQUARE: c = CH_RSQUARE;
      KIND_CURLY:  c = CH_RCURLY;
      default:     c = CH_RROUND;
    endcase
    return c;
  endfunction

endpackage

// ===== src/bmc_cell.sv =====
// One stack cell: holds a single bracket kind and trades it with its
// neighbours. Depends on bmc_pkg.
module bmc_cell
  import bmc_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  kind_t    from_above,
  input  kind_t    from_below,
  output kind_t    kind_o
);

  kind_t kind_r;
  kind_t kind_nxt;

  // Take the upper neighbour on push, the lower one on pop, else hold
  always_comb begin
    kind_nxt = kind_r;
    if (op.shift_down) begin
      kind_nxt = from_above;
    end else if (op.shift_up) begin
      kind_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_o = kind_r;

endmodule

// ===== src/bmc_stack.sv =====
// Bracket stack as a chain of shifting cells with the top in cell 0,
// plus the fill count. Depends on bmc_pkg and bmc_cell.
module bmc_stack
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             empty;
  logic             full;
  logic             push_eff;
  logic             pop_eff;
  cell_op_t         op;
  kind_t            kinds [STACK_DEPTH];

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(STACK_DEPTH));
  assign push_eff = cmd.push && !full;
  assign pop_eff  = cmd.pop && !empty;

  assign op.shift_down = push_eff;
  assign op.shift_up   = pop_eff;

  // Build the chain: cell 0 takes the new kind, the bottom cell holds on pop
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above;
    kind_t below;
    if (i == 0) begin : g_top
      assign above = cmd.kind;
    end else begin : g_mid
      assign above = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = kinds[i];
    end else begin : g_up
      assign below = kinds[i+1];
    end
    bmc_cell u_cell (
      .clk        (clk),
      .op         (op),
      .from_above (above),
      .from_below (below),
      .kind_o     (kinds[i])
    );
  end

  // Advance the fill count; drop to empty at the end of a string
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (push_eff) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_eff) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty = empty;
  assign stat.full  = full;
  assign stat.top   = kinds[0];

endmodule

// ===== src/bracket_match_corrector_unit.sv =====
// Top level of the bracket match corrector: character decode, counters,
// stack and a two-entry output buffer. Depends on bmc_pkg and bmc_stack.
//
// Takes one text byte per cycle while in_stall is low and returns one
// item per byte, back to back. Each result is registered in the output
// register or skid entry. The stack keeps pace as a chain of
// shifting cells with the top kind always held in cell 0. A two-entry output
// buffer lets input continue while a result waits; in_stall rises only when
// both entries are full. Openers are pushed as kind codes, closers pop; a
// mismatched closer is flagged, counted and replaced by the closer that fits
// the popped opener. A closer on an empty stack passes unchanged and a push
// onto a full stack is dropped. Position and error count saturate at 65535
// and clear with stack after the item marked in_last. No clearing pass is
// needed after reset.
module bracket_match_corrector_unit
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        accept;
  logic        take;
  logic        is_open;
  logic        is_close;
  kind_t       open_kind;
  kind_t       close_kind;
  stk_cmd_t    cmd;
  stk_stat_t   stat;
  logic        bad;
  logic [15:0] err_inc;
  out_item_t   res;

  logic [15:0] byte_index_r;
  logic [15:0] byte_index_nxt;
  logic [15:0] error_count_r;
  logic [15:0] error_count_nxt;

  logic        out_v_r;
  logic        out_v_nxt;
  out_item_t   out_r;
  out_item_t   out_nxt;
  logic        skid_v_r;
  logic        skid_v_nxt;
  out_item_t   skid_r;
  out_item_t   skid_nxt;

  assign in_stall = skid_v_r;
  assign accept   = in_valid && !skid_v_r;
  assign take     = out_v_r && !out_stall;

  // Decode the byte
  always_comb begin
    is_open    = 1'b1;
    is_close   = 1'b1;
    open_kind  = KIND_ROUND;
    close_kind = KIND_ROUND;
    case (in_data.in_char)
      CH_LSQUARE: open_kind = KIND_SQUARE;
      CH_LCURLY:  open_kind = KIND_CURLY;
      CH_LROUND:  open_kind = KIND_ROUND;
      default:    is_open   = 1'b0;
    endcase
    case (in_data.in_char)
      CH_RSQUARE: close_kind = KIND_SQUARE;
      CH_RCURLY:  close_kind = KIND_CURLY;
      CH_RROUND:  close_kind = KIND_ROUND;
      default:    is_close   = 1'b0;
    endcase
  end

  assign cmd.push  = accept && is_open;
  assign cmd.pop   = accept && is_close;
  assign cmd.clear = accept && in_data.in_last;
  assign cmd.kind  = open_kind;

  bmc_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Form the result item
  assign bad     = is_close && !stat.empty && (stat.top != close_kind);
  assign err_inc = (bad && error_count_r != SAT_MAX) ? error_count_r + 16'd1
                                                      : error_count_r;

  always_comb begin
    res.out_char    = bad ? kind_closer(stat.top) : in_data.in_char;
    res.mismatch    = bad;
    res.position    = byte_index_r;
    res.error_total = err_inc;
    res.out_last    = in_data.in_last;
  end

  // Advance position and error count, clear them after the last byte
  always_comb begin
    byte_index_nxt  = byte_index_r;
    error_count_nxt = error_count_r;
    if (accept) begin
      if (in_data.in_last) begin
        byte_index_nxt  = '0;
        error_count_nxt = '0;
      end else begin
        byte_index_nxt  = (byte_index_r != SAT_MAX) ? byte_index_r + 16'd1
                                                    : byte_index_r;
        error_count_nxt = err_inc;
      end
    end
  end

  // Output register with skid entry behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (out_v_r && !take) begin
      if (accept) begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else begin
      out_v_nxt = accept;
      if (accept) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r  <= '0;
      error_count_r <= '0;
      out_v_r       <= 1'b0;
      skid_v_r      <= 1'b0;
    end else begin
      byte_index_r  <= byte_index_nxt;
      error_count_r <= error_count_nxt;
      out_v_r       <= out_v_nxt;
      skid_v_r      <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== src/bmc_checker.sv =====
// Port-level checks for the bracket match corrector and the bind that
// attaches them to the top level. Depends on bmc_pkg.
module bmc_checker
  import bmc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  // Stall input only while a result is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A mismatch is always counted
  a_err_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mismatch |-> out_data.error_total != 16'd0)
    else $error("mismatch with zero error total");

  // A corrected byte is always a closer
  a_fix_is_closer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.mismatch |->
      (out_data.out_char == CH_RROUND || out_data.out_char == CH_RSQUARE ||
       out_data.out_char == CH_RCURLY))
    else $error("corrected byte is not a closer");

  // An idle output with nothing offered stays idle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_valid |=> !out_valid)
    else $error("result item appeared with no input item");

endmodule

bind bracket_match_corrector_unit bmc_checker u_bmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== dv/bracket_match_corrector_unit_tb.sv =====
// Self-checking testbench for bracket_match_corrector_unit: drives text strings
// under random bursts and stalls, predicts every result and checks each field.
// Depends on bmc_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module bracket_match_corrector_unit_tb
  import bmc_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned REPORT_CAP   = 40;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // Stack-based predictor and store of expected result items
  class bracket_scoreboard;
    kind_t       open_stack [STACK_DEPTH];
    int unsigned depth_used;
    logic [15:0] next_pos;
    logic [15:0] err_cnt;
    out_item_t   expected_q [$];
    int unsigned failures;

    function new();
      depth_used = 0;
      next_pos   = '0;
      err_cnt    = '0;
      failures   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
      failures++;
      if (failures <= REPORT_CAP)
        $error("%s: expected %0h, got %0h", field, want, got);
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_input(in_item_t it);
      out_item_t exp_item;
      kind_t     top;
      exp_item.out_char = it.in_char;
      exp_item.mismatch = 1'b0;
      case (it.in_char)
        CH_LROUND, CH_LSQUARE, CH_LCURLY: begin
          // drop the opener when the stack is full
          if (depth_used < STACK_DEPTH) begin
            open_stack[depth_used] = (it.in_char == CH_LROUND)  ? KIND_ROUND :
                                     (it.in_char == CH_LSQUARE) ? KIND_SQUARE : KIND_CURLY;
            depth_used++;
          end
        end
        CH_RROUND, CH_RSQUARE, CH_RCURLY: begin
          // a closer on an empty stack passes unchanged
          if (depth_used > 0) begin
            depth_used--;
            top = open_stack[depth_used];
            if ((top == KIND_ROUND  && it.in_char != CH_RROUND)  ||
                (top == KIND_SQUARE && it.in_char != CH_RSQUARE) ||
                (top == KIND_CURLY  && it.in_char != CH_RCURLY)  ||
                (top != KIND_ROUND && top != KIND_SQUARE && top != KIND_CURLY)) begin
              exp_item.mismatch = (top == KIND_ROUND  && it.in_char == CH_RROUND) ? 1'b0 : 1'b1;
              if (exp_item.mismatch) begin
                if (err_cnt != SAT_MAX) err_cnt++;
                case (top)
                  KIND_SQUARE: exp_item.out_char = CH_RSQUARE;
                  KIND_CURLY:  exp_item.out_char = CH_RCURLY;
                  default:     exp_item.out_char = CH_RROUND;
                endcase
              end
            end
          end
        end
        default: ;
      endcase
      exp_item.position    = next_pos;
      exp_item.error_total = err_cnt;
      exp_item.out_last    = it.in_last;
      expected_q.push_back(exp_item);
      if (next_pos != SAT_MAX) next_pos++;
      // clear string state after the final byte
      if (it.in_last) begin
        depth_used = 0;
        next_pos   = '0;
        err_cnt    = '0;
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $error("out_data: unexpected item %0h with nothing expected", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_char !== want.out_char)
        flag("out_char", 16'(want.out_char), 16'(got.out_char));
      if (got.mismatch !== want.mismatch)
        flag("mismatch", 16'(want.mismatch), 16'(got.mismatch));
      if (got.position !== want.position)
        flag("position", want.position, got.position);
      if (got.error_total !== want.error_total)
        flag("error_total", want.error_total, got.error_total);
      if (got.out_last !== want.out_last)
        flag("out_last", 16'(want.out_last), 16'(got.out_last));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Values seen mid-cycle, used at the next rising edge
  logic      rst_s, in_valid_s, in_stall_s, out_valid_s, out_stall_s;
  in_item_t  in_data_s;
  out_item_t out_data_s;

  bracket_scoreboard sb;
  int unsigned       cycles = 0;
  int unsigned       burst_left = 0;
  int unsigned       random_sent = 0;
  rx_mode_t          rx_mode = RX_FREE;
  int unsigned       rx_left = 0;
  int unsigned       rx_phase = 0;

  bracket_match_corrector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial sb = new();

  // Sample handshake signals away from the clock edge
  always @(negedge clk) begin
    rst_s       = rst_n;
    in_valid_s  = in_valid;
    in_stall_s  = in_stall;
    in_data_s   = in_data;
    out_valid_s = out_valid;
    out_stall_s = out_stall;
    out_data_s  = out_data;
  end

  // Note accepted items and check accepted results
  always @(posedge clk) begin
    if (rst_s === 1'b1) begin
      if (in_valid_s && in_stall_s === 1'b0)
        sb.note_input(in_data_s);
      if (out_valid_s === 1'b1 && !out_stall_s)
        sb.check_result(out_data_s);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls: free, random or a fixed repeating pattern, switched now and then
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
      RX_PATTERN: out_stall <= ((rx_phase % 8) < 5);
      default:    out_stall <= 1'b0;
    endcase
  end

  function automatic logic [7:0] open_char(kind_t k);
    case (k)
      KIND_ROUND:  return CH_LROUND;
      KIND_SQUARE: return CH_LSQUARE;
      default:     return CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(kind_t k);
    case (k)
      KIND_ROUND:  return CH_RROUND;
      KIND_SQUARE: return CH_RSQUARE;
      default:     return CH_RCURLY;
    endcase
  endfunction

  function automatic kind_t any_kind();
    return kind_t'($urandom_range(KIND_ROUND, KIND_CURLY));
  endfunction

  function automatic kind_t other_kind(kind_t k);
    kind_t w;
    do w = any_kind(); while (w == k);
    return w;
  endfunction

  // Offer one item, in bursts with random gaps, and hold it until accepted
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_char: ch, in_last: last};
    do @(posedge clk); while (in_stall_s !== 1'b0);
    burst_left--;
  endtask

  // Mostly nested bracket text with filler and the odd wrong closer; some pure noise
  task automatic send_random_string(input int unsigned len);
    kind_t       open_kinds [$];
    kind_t       k;
    int unsigned r;
    logic [7:0]  ch;
    logic        noise;
    noise = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (noise) begin
        if (r < 20)      ch = open_char(any_kind());
        else if (r < 40) ch = close_char(any_kind());
        else             ch = 8'($urandom_range(0, 255));
      end else if (open_kinds.size() > 0 && r < 40) begin
        k = open_kinds.pop_back();
        if ($urandom_range(0, 9) == 0) k = other_kind(k);
        ch = close_char(k);
      end else if (r < 85) begin
        k = any_kind();
        open_kinds.push_back(k);
        ch = open_char(k);
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      send_byte(ch, i == len - 1);
      random_sent++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: closer on empty stack, every pairing, filler extremes, last marks
    send_byte(CH_RROUND,  1'b0);
    send_byte(CH_LROUND,  1'b0);
    send_byte(CH_RSQUARE, 1'b0);
    send_byte(CH_LSQUARE, 1'b0);
    send_byte(CH_RSQUARE, 1'b0);
    send_byte(CH_LCURLY,  1'b0);
    send_byte(CH_RROUND,  1'b0);
    send_byte(CH_LCURLY,  1'b0);
    send_byte(CH_RCURLY,  1'b0);
    send_byte(CH_LROUND,  1'b0);
    send_byte(CH_RCURLY,  1'b0);
    send_byte(CH_LSQUARE, 1'b0);
    send_byte(CH_RCURLY,  1'b0);
    send_byte(CH_LSQUARE, 1'b0);
    send_byte(CH_RROUND,  1'b0);
    send_byte(8'h00,      1'b0);
    send_byte(8'hFF,      1'b0);
    send_byte(CH_LCURLY,  1'b0);
    send_byte(CH_RSQUARE, 1'b0);
    send_byte(CH_LROUND,  1'b0);
    send_byte(CH_LROUND,  1'b0);
    send_byte(CH_RROUND,  1'b1);
    send_byte(CH_RCURLY,  1'b1);
    send_byte(8'hFF,      1'b1);
    send_byte(8'h00,      1'b1);

    // Random strings; shows the counters cleared between strings
    while (random_sent < RANDOM_ITEMS)
      send_random_string(($urandom_range(0, 9) == 0) ? $urandom_range(1, 200)
                                                     : $urandom_range(1, 40));
    in_valid <= 1'b0;

    // Drain, then wait for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
